@@ hw/rtl/fmbq_pkg.sv @@
`default_nettype none
package fmbq_pkg;

	// queue geometry
	localparam int CAPACITY   = 1024;
	localparam int DATA_W     = 32;
	localparam int HALF_DEPTH = CAPACITY / 2 + 1;
	localparam int IDX_W      = $clog2(HALF_DEPTH);
	localparam int COUNT_W    = $clog2(CAPACITY + 1);
	localparam int MODE_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int IN_TDATA_W  = ((DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;

	localparam logic [IDX_W:0]     HALF_DEPTH_X = (IDX_W + 1)'(HALF_DEPTH);
	localparam logic [IDX_W-1:0]   LAST_IDX     = IDX_W'(HALF_DEPTH - 1);
	localparam logic [COUNT_W-1:0] CAP_COUNT    = COUNT_W'(CAPACITY);

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [DATA_W-1:0] data_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FRONT  = 3'd0,
		MODE_PUSH_MIDDLE = 3'd1,
		MODE_PUSH_BACK   = 3'd2,
		MODE_POP_FRONT   = 3'd3,
		MODE_POP_MIDDLE  = 3'd4,
		MODE_POP_BACK    = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_MOVE
	} state_t;

	// ring index arithmetic, both operands below HALF_DEPTH
	function automatic idx_t ring_add(input idx_t a, input idx_t b);
		logic [IDX_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= HALF_DEPTH_X) begin
			sum = sum - HALF_DEPTH_X;
		end
		return sum[IDX_W-1:0];
	endfunction

	function automatic idx_t ring_inc(input idx_t a);
		return (a == LAST_IDX) ? '0 : idx_t'(a + 1'b1);
	endfunction

	function automatic idx_t ring_dec(input idx_t a);
		return (a == '0) ? LAST_IDX : idx_t'(a - 1'b1);
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fmbq_ram.sv @@
`default_nettype none
module fmbq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 513
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/front_middle_back_queue.sv @@
// A request accepted in the idle state moves the block to the move state; the
// result is loaded into the output register as the move state ends.
// No request is taken in the move state, which carries the at most one
// rebalancing move between the two half stores, each a registered-read RAM.
// A result still waiting at the output holds off the next request.
// Reset: both halves empty, ring starts at zero; store contents are not
// cleared, so the block takes requests right after reset.
`default_nettype none
module front_middle_back_queue (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [fmbq_pkg::IN_TDATA_W-1:0]     s_tdata,  // push_value
	input  wire logic [fmbq_pkg::MODE_W-1:0]         s_tuser,  // mode
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [fmbq_pkg::OUT_TDATA_W-1:0]    m_tdata,  // pop_value, item_count
	output logic      [fmbq_pkg::STATUS_W-1:0]       m_tuser   // status
);

	fmbq_pkg::state_t state_q, state_nxt;

	// half descriptors
	fmbq_pkg::idx_t fst_q, fs_q, bst_q, bs_q;
	fmbq_pkg::idx_t fst_nxt, fs_nxt, bst_nxt, bs_nxt;

	logic                              acc;
	logic [fmbq_pkg::COUNT_W-1:0]      n;
	fmbq_pkg::data_t                   push_value;

	// request decode, used as the request is accepted
	logic                              f_we0, b_we0, f_re, b_re;
	fmbq_pkg::idx_t                    w0_addr, f_raddr, b_raddr;
	logic                              pop_f, pop_b, ones;
	logic                              mv_en, mv_f2b;
	fmbq_pkg::idx_t                    mv_waddr;
	fmbq_pkg::status_t                 status;

	// decode registered at acceptance, used in the move state
	logic                              pop_f_s1, pop_b_s1, ones_s1;
	logic                              mv_en_s1, mv_f2b_s1;
	fmbq_pkg::idx_t                    mv_waddr_s1;
	fmbq_pkg::status_t                 status_s1;
	logic [fmbq_pkg::COUNT_W-1:0]      count_s1;

	// output register
	logic                              m_tvalid_q;
	fmbq_pkg::data_t                   pop_value_q;
	fmbq_pkg::status_t                 status_q;
	logic [fmbq_pkg::COUNT_W-1:0]      count_q;

	// ram ports
	logic                              f_wr_en, b_wr_en;
	fmbq_pkg::idx_t                    f_wr_addr, b_wr_addr;
	fmbq_pkg::data_t                   f_wr_data, b_wr_data, f_rd_data, b_rd_data;

	assign acc        = s_tvalid && s_tready;
	assign n          = fmbq_pkg::COUNT_W'(fs_q) + fmbq_pkg::COUNT_W'(bs_q);
	assign push_value = s_tdata[fmbq_pkg::DATA_W-1:0];

	// operation decode with the follow-up rebalance folded in
	always_comb begin
		fst_nxt  = fst_q;
		fs_nxt   = fs_q;
		bst_nxt  = bst_q;
		bs_nxt   = bs_q;
		f_we0    = 1'b0;
		b_we0    = 1'b0;
		w0_addr  = '0;
		f_re     = 1'b0;
		b_re     = 1'b0;
		f_raddr  = '0;
		b_raddr  = '0;
		pop_f    = 1'b0;
		pop_b    = 1'b0;
		ones     = 1'b0;
		mv_en    = 1'b0;
		mv_f2b   = 1'b0;
		mv_waddr = '0;
		status   = fmbq_pkg::STATUS_OK;
		case (s_tuser)
			fmbq_pkg::MODE_PUSH_FRONT: begin
				if (n >= fmbq_pkg::CAP_COUNT) begin
					status = fmbq_pkg::STATUS_FULL;
				end else if (n == '0) begin
					b_we0   = 1'b1;
					w0_addr = fmbq_pkg::ring_dec(bst_q);
					bst_nxt = fmbq_pkg::ring_dec(bst_q);
					bs_nxt  = fmbq_pkg::idx_t'(1);
				end else begin
					f_we0   = 1'b1;
					w0_addr = fmbq_pkg::ring_dec(fst_q);
					fst_nxt = fmbq_pkg::ring_dec(fst_q);
					fs_nxt  = fmbq_pkg::idx_t'(fs_q + 1'b1);
					// front half grew past the back half: its last moves over
					if (fs_q == bs_q) begin
						fs_nxt   = fs_q;
						f_re     = 1'b1;
						f_raddr  = fmbq_pkg::ring_add(fst_q, fmbq_pkg::idx_t'(fs_q - 1'b1));
						mv_en    = 1'b1;
						mv_f2b   = 1'b1;
						mv_waddr = fmbq_pkg::ring_dec(bst_q);
						bst_nxt  = fmbq_pkg::ring_dec(bst_q);
						bs_nxt   = fmbq_pkg::idx_t'(bs_q + 1'b1);
					end
				end
			end
			fmbq_pkg::MODE_PUSH_MIDDLE: begin
				if (n >= fmbq_pkg::CAP_COUNT) begin
					status = fmbq_pkg::STATUS_FULL;
				end else if (n[0]) begin
					// odd count: the new middle ends up at the back of the front half
					f_we0   = 1'b1;
					w0_addr = fmbq_pkg::ring_add(fst_q, fs_q);
					fs_nxt  = fmbq_pkg::idx_t'(fs_q + 1'b1);
				end else begin
					b_we0   = 1'b1;
					w0_addr = fmbq_pkg::ring_dec(bst_q);
					bst_nxt = fmbq_pkg::ring_dec(bst_q);
					bs_nxt  = fmbq_pkg::idx_t'(bs_q + 1'b1);
				end
			end
			fmbq_pkg::MODE_PUSH_BACK: begin
				if (n >= fmbq_pkg::CAP_COUNT) begin
					status = fmbq_pkg::STATUS_FULL;
				end else begin
					b_we0   = 1'b1;
					w0_addr = fmbq_pkg::ring_add(bst_q, bs_q);
					bs_nxt  = fmbq_pkg::idx_t'(bs_q + 1'b1);
					// back half two ahead: its first moves to the front half
					if (bs_q == fmbq_pkg::idx_t'(fs_q + 1'b1)) begin
						bs_nxt   = bs_q;
						b_re     = 1'b1;
						b_raddr  = bst_q;
						bst_nxt  = fmbq_pkg::ring_inc(bst_q);
						mv_en    = 1'b1;
						mv_waddr = fmbq_pkg::ring_add(fst_q, fs_q);
						fs_nxt   = fmbq_pkg::idx_t'(fs_q + 1'b1);
					end
				end
			end
			fmbq_pkg::MODE_POP_FRONT: begin
				if (n == '0) begin
					status = fmbq_pkg::STATUS_EMPTY;
					ones   = 1'b1;
				end else if (fs_q == '0) begin
					b_re    = 1'b1;
					b_raddr = bst_q;
					pop_b   = 1'b1;
					bst_nxt = fmbq_pkg::ring_inc(bst_q);
					bs_nxt  = fmbq_pkg::idx_t'(bs_q - 1'b1);
				end else begin
					f_re    = 1'b1;
					f_raddr = fst_q;
					pop_f   = 1'b1;
					fst_nxt = fmbq_pkg::ring_inc(fst_q);
					fs_nxt  = fmbq_pkg::idx_t'(fs_q - 1'b1);
					if (bs_q != fs_q) begin
						fs_nxt   = fs_q;
						b_re     = 1'b1;
						b_raddr  = bst_q;
						bst_nxt  = fmbq_pkg::ring_inc(bst_q);
						bs_nxt   = fmbq_pkg::idx_t'(bs_q - 1'b1);
						mv_en    = 1'b1;
						mv_waddr = fmbq_pkg::ring_add(fst_q, fs_q);
					end
				end
			end
			fmbq_pkg::MODE_POP_MIDDLE: begin
				if (n == '0) begin
					status = fmbq_pkg::STATUS_EMPTY;
					ones   = 1'b1;
				end else if (n[0]) begin
					b_re    = 1'b1;
					b_raddr = bst_q;
					pop_b   = 1'b1;
					bst_nxt = fmbq_pkg::ring_inc(bst_q);
					bs_nxt  = fmbq_pkg::idx_t'(bs_q - 1'b1);
				end else begin
					f_re    = 1'b1;
					f_raddr = fmbq_pkg::ring_add(fst_q, fmbq_pkg::idx_t'(fs_q - 1'b1));
					pop_f   = 1'b1;
					fs_nxt  = fmbq_pkg::idx_t'(fs_q - 1'b1);
				end
			end
			fmbq_pkg::MODE_POP_BACK: begin
				if (n == '0) begin
					status = fmbq_pkg::STATUS_EMPTY;
					ones   = 1'b1;
				end else begin
					b_re    = 1'b1;
					b_raddr = fmbq_pkg::ring_add(bst_q, fmbq_pkg::idx_t'(bs_q - 1'b1));
					pop_b   = 1'b1;
					bs_nxt  = fmbq_pkg::idx_t'(bs_q - 1'b1);
					if (bs_q == fs_q) begin
						bs_nxt   = bs_q;
						f_re     = 1'b1;
						f_raddr  = fmbq_pkg::ring_add(fst_q, fmbq_pkg::idx_t'(fs_q - 1'b1));
						fs_nxt   = fmbq_pkg::idx_t'(fs_q - 1'b1);
						mv_en    = 1'b1;
						mv_f2b   = 1'b1;
						mv_waddr = fmbq_pkg::ring_dec(bst_q);
						bst_nxt  = fmbq_pkg::ring_dec(bst_q);
					end
				end
			end
			default: begin
				status = fmbq_pkg::STATUS_OK;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmbq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and request handshake
	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		case (state_q)
			fmbq_pkg::ST_IDLE: begin
				s_tready = !m_tvalid_q || m_tready;
				if (s_tvalid && s_tready) begin
					state_nxt = fmbq_pkg::ST_MOVE;
				end
			end
			fmbq_pkg::ST_MOVE: begin
				state_nxt = fmbq_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = fmbq_pkg::ST_IDLE;
			end
		endcase
	end

	// half descriptors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= '0;
			fs_q  <= '0;
			bst_q <= '0;
			bs_q  <= '0;
		end else if (acc) begin
			fst_q <= fst_nxt;
			fs_q  <= fs_nxt;
			bst_q <= bst_nxt;
			bs_q  <= bs_nxt;
		end
	end

	// decode registered at acceptance, used in the move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_en_s1 <= 1'b0;
		end else begin
			mv_en_s1 <= acc && mv_en;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pop_f_s1    <= pop_f;
			pop_b_s1    <= pop_b;
			ones_s1     <= ones;
			mv_f2b_s1   <= mv_f2b;
			mv_waddr_s1 <= mv_waddr;
			status_s1   <= status;
			count_s1    <= fmbq_pkg::COUNT_W'(fs_nxt) + fmbq_pkg::COUNT_W'(bs_nxt);
		end
	end

	// ram write ports: pushes in the idle state as the request is accepted, the move in the move state
	always_comb begin
		if (state_q == fmbq_pkg::ST_MOVE) begin
			f_wr_en   = mv_en_s1 && !mv_f2b_s1;
			b_wr_en   = mv_en_s1 && mv_f2b_s1;
			f_wr_addr = mv_waddr_s1;
			b_wr_addr = mv_waddr_s1;
			f_wr_data = b_rd_data;
			b_wr_data = f_rd_data;
		end else begin
			f_wr_en   = acc && f_we0;
			b_wr_en   = acc && b_we0;
			f_wr_addr = w0_addr;
			b_wr_addr = w0_addr;
			f_wr_data = push_value;
			b_wr_data = push_value;
		end
	end

	fmbq_ram #(
		.WIDTH(fmbq_pkg::DATA_W),
		.DEPTH(fmbq_pkg::HALF_DEPTH)
	) u_front_ram (
		.clk     (clk),
		.wr_en   (f_wr_en),
		.wr_addr (f_wr_addr),
		.wr_data (f_wr_data),
		.rd_en   (acc && f_re),
		.rd_addr (f_raddr),
		.rd_data (f_rd_data)
	);

	fmbq_ram #(
		.WIDTH(fmbq_pkg::DATA_W),
		.DEPTH(fmbq_pkg::HALF_DEPTH)
	) u_back_ram (
		.clk     (clk),
		.wr_en   (b_wr_en),
		.wr_addr (b_wr_addr),
		.wr_data (b_wr_data),
		.rd_en   (acc && b_re),
		.rd_addr (b_raddr),
		.rd_data (b_rd_data)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == fmbq_pkg::ST_MOVE) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fmbq_pkg::ST_MOVE) begin
			status_q <= status_s1;
			count_q  <= count_s1;
			if (pop_f_s1) begin
				pop_value_q <= f_rd_data;
			end else if (pop_b_s1) begin
				pop_value_q <= b_rd_data;
			end else if (ones_s1) begin
				pop_value_q <= '1;
			end else begin
				pop_value_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = fmbq_pkg::OUT_TDATA_W'({count_q, pop_value_q});
	assign m_tuser  = status_q;

endmodule
`default_nettype wire
